>>> rtl/core/ztc_pkg.sv
// ============================================================================
// ztc_pkg
// Shared types and constants for the zone thermostat controller.
// ============================================================================
package ztc_pkg;

    localparam int ROOMS_DEFAULT = 4;

    localparam int TEMP_W  = 12;
    localparam int BAND_W  = 8;
    localparam int MODE_W  = 2;
    localparam int ROOM_W  = 2;
    localparam int LIVE_W  = 4;
    localparam int FAN_W   = 8;
    localparam int MASK_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // System modes.
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COOL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEAT = 2'd2;

    // Item kinds.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Register indexes of the write port.
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_ZONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_BAND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_BAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_WAIT  = 3'd5;

    // Reset values.
    localparam logic signed [TEMP_W-1:0] SETPOINT_RST  = 12'sd88;
    localparam logic signed [TEMP_W-1:0] TEMP_RST      = 12'sd88;
    localparam logic [BAND_W-1:0]        NORM_BAND_RST = 8'd4;
    localparam logic [BAND_W-1:0]        PRIO_BAND_RST = 8'd2;
    localparam logic [FAN_W-1:0]         FAN_WAIT_RST  = 8'd3;

    localparam logic [LIVE_W-1:0] LIVE_RELOAD = 4'hF;

    // Decision of the compare unit for one room.
    typedef struct packed {
        logic act;   // the room's vent command is set this tick
        logic open;  // value it is set to
    } ztc_want_t;

    // Relay bits.
    typedef struct packed {
        logic fan;
        logic cool;
        logic heat;
    } ztc_relay_t;

endpackage

>>> rtl/core/ztc_cmd_if.sv
// ============================================================================
// ztc_cmd_if
// Input channel: temperature reports and control ticks.
// ============================================================================
interface ztc_cmd_if
    import ztc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [ROOM_W-1:0]        room;
    logic signed [TEMP_W-1:0] reading;

    modport source (output valid, output kind, output room, output reading, input ready);
    modport sink   (input valid, input kind, input room, input reading, output ready);
endinterface

>>> rtl/core/ztc_status_if.sv
// ============================================================================
// ztc_status_if
// Output channel: relay drives, vent masks and liveness status.
// ============================================================================
interface ztc_status_if
    import ztc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              heat_on;
    logic              cool_on;
    logic              fan_on;
    logic              hvac_running;
    logic [MASK_W-1:0] vents_open;
    logic [MASK_W-1:0] vents_changed;
    logic [MASK_W-1:0] zones_stale;

    modport source (
        output valid, output heat_on, output cool_on, output fan_on,
        output hvac_running, output vents_open, output vents_changed,
        output zones_stale, input ready
    );
    modport sink (
        input valid, input heat_on, input cool_on, input fan_on,
        input hvac_running, input vents_open, input vents_changed,
        input zones_stale, output ready
    );
endinterface

>>> rtl/core/ztc_zone_cmp.sv
// ============================================================================
// ztc_zone_cmp
// Shared hysteresis compare unit, evaluated for one room per cycle.
// ============================================================================
module ztc_zone_cmp
    import ztc_pkg::*;
(
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [TEMP_W-1:0] temp,
    input  logic signed [TEMP_W-1:0] setpoint,
    input  logic [BAND_W-1:0]        open_band,
    input  logic [BAND_W-1:0]        normal_band,
    output ztc_want_t                want
);

    localparam int EXT_W = TEMP_W + 1;

    logic signed [EXT_W-1:0] temp_x;
    logic signed [EXT_W-1:0] sp_x;
    logic signed [EXT_W-1:0] ob_x;
    logic signed [EXT_W-1:0] nb_x;
    logic signed [EXT_W-1:0] open_hi;
    logic signed [EXT_W-1:0] open_lo;
    logic signed [EXT_W-1:0] close_hi;
    logic signed [EXT_W-1:0] close_lo;

    // The sums stay within 13 bits for every setpoint and band.
    assign temp_x   = {temp[TEMP_W-1], temp};
    assign sp_x     = {setpoint[TEMP_W-1], setpoint};
    assign ob_x     = {{(EXT_W-BAND_W){1'b0}}, open_band};
    assign nb_x     = {{(EXT_W-BAND_W){1'b0}}, normal_band};
    assign open_hi  = sp_x + ob_x;
    assign open_lo  = sp_x - ob_x;
    assign close_hi = sp_x + nb_x;
    assign close_lo = sp_x - nb_x;

    always_comb
    begin
        want = '0;
        unique case (mode)
            MODE_COOL:
            begin
                if (temp_x > open_hi)
                begin
                    want.act  = 1'b1;
                    want.open = 1'b1;
                end
                else if (temp_x < close_lo)
                begin
                    want.act  = 1'b1;
                    want.open = 1'b0;
                end
            end
            MODE_HEAT:
            begin
                if (temp_x < open_lo)
                begin
                    want.act  = 1'b1;
                    want.open = 1'b1;
                end
                else if (temp_x > close_hi)
                begin
                    want.act  = 1'b1;
                    want.open = 1'b0;
                end
            end
            default:
            begin
                want = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/zone_thermostat_controller.sv
// ============================================================================
// zone_thermostat_controller
// Multi-room thermostat: stores room reports and, on each control tick,
// walks the rooms through one shared hysteresis compare unit.
// ============================================================================
//
//  Channel   Dir   Handshake        Word
//  cmd       in    valid/ready      kind, room, reading
//  status    out   valid/ready      heat_on, cool_on, fan_on, hvac_running,
//                                   vents_open, vents_changed, zones_stale
//  cfg_*     in    write enable     cfg_index, cfg_data
//
//  A report goes from the idle state to the done state; a tick passes
//  through the scan state, one room per cycle in the shared compare unit,
//  the finish state, which settles relays, fan and liveness, and the done
//  state, which loads the output register. cmd is ready again once the
//  sequencer is back in idle, and only while it is idle; a finished status
//  word waits in the output register, and the next word is held back only
//  while that register is still full. Reset is immediate; no clearing pass.
//
module zone_thermostat_controller
    import ztc_pkg::*;
#(
    parameter int ROOMS = ROOMS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ztc_cmd_if.sink               cmd,
    ztc_status_if.source          status
);

    localparam int IDX_W      = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int MASK_ROOMS = (ROOMS < MASK_W) ? ROOMS : MASK_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    // Configuration.
    logic signed [TEMP_W-1:0] setpoint_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic [ROOM_W-1:0]        prio_zone_reg;
    logic [BAND_W-1:0]        norm_band_reg;
    logic [BAND_W-1:0]        prio_band_reg;
    logic [FAN_W-1:0]         fan_wait_reg;

    // Room state.
    logic signed [TEMP_W-1:0] temp_reg [ROOMS];
    logic                     vent_reg [ROOMS];
    logic [LIVE_W-1:0]        live_reg [ROOMS];

    // System state.
    logic              running_reg;
    logic [FAN_W-1:0]  fan_count_reg;
    ztc_relay_t        relays_reg;

    // Sequencer.
    logic [1:0]        state_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              any_reg;
    logic [MASK_W-1:0] changed_reg;

    // Output register.
    logic              out_valid_reg;
    ztc_relay_t        out_relays_reg;
    logic              out_running_reg;
    logic [MASK_W-1:0] out_vents_reg;
    logic [MASK_W-1:0] out_changed_reg;
    logic [MASK_W-1:0] out_stale_reg;

    logic              cmd_fire;
    logic              room_ok;
    logic [IDX_W-1:0]  room_idx;
    logic              is_prio;
    logic [BAND_W-1:0] open_band;
    ztc_want_t         want;

    ztc_relay_t        relays_next;
    logic              running_next;
    logic [FAN_W-1:0]  fan_count_next;

    logic [MASK_W-1:0] vents_mask;
    logic [MASK_W-1:0] stale_mask;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign room_ok   = (32'(cmd.room) < ROOMS);
    assign room_idx  = IDX_W'(cmd.room);

    assign is_prio   = (32'(idx_reg) == 32'(prio_zone_reg));
    assign open_band = is_prio ? prio_band_reg : norm_band_reg;

    ztc_zone_cmp u_cmp (
        .mode        (mode_reg),
        .temp        (temp_reg[idx_reg]),
        .setpoint    (setpoint_reg),
        .open_band   (open_band),
        .normal_band (norm_band_reg),
        .want        (want)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= SETPOINT_RST;
            mode_reg      <= MODE_OFF;
            prio_zone_reg <= '0;
            norm_band_reg <= NORM_BAND_RST;
            prio_band_reg <= PRIO_BAND_RST;
            fan_wait_reg  <= FAN_WAIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETPOINT:  setpoint_reg  <= cfg_data[TEMP_W-1:0];
                REG_MODE:      mode_reg      <= cfg_data[MODE_W-1:0];
                REG_PRIO_ZONE: prio_zone_reg <= cfg_data[ROOM_W-1:0];
                REG_NORM_BAND: norm_band_reg <= cfg_data[BAND_W-1:0];
                REG_PRIO_BAND: prio_band_reg <= cfg_data[BAND_W-1:0];
                REG_FAN_WAIT:  fan_wait_reg  <= cfg_data[FAN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Start, stop and fan delay, settled after the last room.
    always_comb
    begin
        relays_next    = relays_reg;
        running_next   = running_reg;
        fan_count_next = fan_count_reg;
        if (any_reg)
        begin
            if (!running_reg)
            begin
                relays_next      = '0;
                relays_next.cool = (mode_reg == MODE_COOL);
                relays_next.heat = (mode_reg == MODE_HEAT);
                fan_count_next   = FAN_W'(1);
                running_next     = 1'b1;
            end
        end
        else if (running_reg)
        begin
            relays_next    = '0;
            fan_count_next = '0;
            running_next   = 1'b0;
        end
        if (fan_count_next != '0)
        begin
            if (fan_count_next == fan_wait_reg)
            begin
                relays_next.fan = 1'b1;
                fan_count_next  = '0;
            end
            else
            begin
                fan_count_next = fan_count_next + FAN_W'(1);
            end
        end
    end

    // Room state: reports, vent updates and liveness countdown.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROOMS; i++)
            begin
                temp_reg[i] <= TEMP_RST;
                vent_reg[i] <= 1'b0;
                live_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd_fire && cmd.kind == KIND_REPORT && room_ok)
            begin
                temp_reg[room_idx] <= cmd.reading;
                live_reg[room_idx] <= LIVE_RELOAD;
            end
            if (state_reg == ST_SCAN && want.act)
            begin
                vent_reg[idx_reg] <= want.open;
            end
            if (state_reg == ST_FINISH)
            begin
                for (int i = 0; i < ROOMS; i++)
                begin
                    if (live_reg[i] != '0)
                    begin
                        live_reg[i] <= live_reg[i] - LIVE_W'(1);
                    end
                end
            end
        end
    end

    // Sequencer and system state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            any_reg       <= 1'b0;
            changed_reg   <= '0;
            running_reg   <= 1'b0;
            fan_count_reg <= '0;
            relays_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        idx_reg     <= '0;
                        any_reg     <= 1'b0;
                        changed_reg <= '0;
                        state_reg   <= (cmd.kind == KIND_TICK) ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN:
                begin
                    if (want.act && want.open)
                    begin
                        any_reg <= 1'b1;
                    end
                    for (int i = 0; i < MASK_ROOMS; i++)
                    begin
                        if (32'(idx_reg) == i && want.act && (vent_reg[i] != want.open))
                        begin
                            changed_reg[i] <= 1'b1;
                        end
                    end
                    if (idx_reg == IDX_W'(ROOMS - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_FINISH:
                begin
                    relays_reg    <= relays_next;
                    running_reg   <= running_next;
                    fan_count_reg <= fan_count_next;
                    state_reg     <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || status.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        vents_mask = '0;
        stale_mask = '0;
        for (int i = 0; i < MASK_ROOMS; i++)
        begin
            vents_mask[i] = vent_reg[i];
            stale_mask[i] = (live_reg[i] == '0);
        end
    end

    // Output register: loaded once the item is settled and the slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && (!out_valid_reg || status.ready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!out_valid_reg || status.ready))
        begin
            out_relays_reg  <= relays_reg;
            out_running_reg <= running_reg;
            out_vents_reg   <= vents_mask;
            out_changed_reg <= changed_reg;
            out_stale_reg   <= stale_mask;
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.heat_on       = out_relays_reg.heat;
    assign status.cool_on       = out_relays_reg.cool;
    assign status.fan_on        = out_relays_reg.fan;
    assign status.hvac_running  = out_running_reg;
    assign status.vents_open    = out_vents_reg;
    assign status.vents_changed = out_changed_reg;
    assign status.zones_stale   = out_stale_reg;

    // Heating and cooling are never driven together.
    a_relay_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(relays_reg.heat && relays_reg.cool))
        else $error("heat and cool relays both on");

    // The fan and the fan counter only run while the system is active.
    a_fan_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (relays_reg.fan || fan_count_reg != '0) |-> running_reg)
        else $error("fan active while system stopped");

    // A new status word is only loaded from the settled state.
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("status word loaded outside the done state");

    // An accepted tick starts the room scan at the first room.
    a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.kind == KIND_TICK) |=> (state_reg == ST_SCAN && idx_reg == '0))
        else $error("tick did not start a room scan");

endmodule

>>> dv/ztc_status_checker.sv
// ============================================================================
// ztc_status_checker
// Watches the command, status and register write traffic of the zone
// thermostat controller. It keeps its own copy of the room state and the
// registers, predicts one status word per accepted command word, and
// compares every status word, field by field, with the oldest prediction.
// ============================================================================
module ztc_status_checker
    import ztc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ztc_cmd_if                    cmd,
    ztc_status_if                 status,
    output int                    mismatches,
    output int                    pending
);

    localparam int ROOM_COUNT = ROOMS_DEFAULT;

    typedef struct packed {
        logic              heat_on;
        logic              cool_on;
        logic              fan_on;
        logic              hvac_running;
        logic [MASK_W-1:0] vents_open;
        logic [MASK_W-1:0] vents_changed;
        logic [MASK_W-1:0] zones_stale;
    } status_word_t;

    // Register copies.
    logic signed [TEMP_W-1:0] setpoint;
    logic [MODE_W-1:0]        mode;
    logic [ROOM_W-1:0]        prio_zone;
    logic [BAND_W-1:0]        norm_band;
    logic [BAND_W-1:0]        prio_band;
    logic [FAN_W-1:0]         fan_wait;

    // Room and system state.
    logic signed [TEMP_W-1:0] room_temp [ROOM_COUNT];
    logic [LIVE_W-1:0]        live_count [ROOM_COUNT];
    logic [ROOM_COUNT-1:0]    vent_open;
    logic                     running;
    logic [FAN_W-1:0]         fan_count;
    ztc_relay_t               relays;

    status_word_t expected_status [$];
    int           words_checked;

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] status word %0d: %s is 0x%0h, expected 0x%0h",
                 $time, words_checked, field, got, want);
        mismatches++;
    endtask

    // Applies one command word to the state copy and returns the status
    // word that the controller should send for it.
    function automatic status_word_t advance_controller(logic kind,
                                                        logic [ROOM_W-1:0] room,
                                                        logic signed [TEMP_W-1:0] reading);
        status_word_t      w;
        ztc_want_t         decision;
        logic [MASK_W-1:0] changed;
        logic              opened;
        int                sp;
        int                t;
        int                open_band;
        int                close_band;
        w       = '0;
        changed = '0;
        opened  = 1'b0;
        sp      = setpoint;
        if (kind == KIND_TICK) begin
            for (int i = 0; i < ROOM_COUNT; i++) begin
                open_band  = (i == int'(prio_zone)) ? prio_band : norm_band;
                close_band = norm_band;
                t          = room_temp[i];
                decision   = '0;
                if (mode == MODE_COOL) begin
                    if (t > sp + open_band)
                        decision = '{act: 1'b1, open: 1'b1};
                    else if (t < sp - close_band)
                        decision = '{act: 1'b1, open: 1'b0};
                end
                else if (mode == MODE_HEAT) begin
                    if (t < sp - open_band)
                        decision = '{act: 1'b1, open: 1'b1};
                    else if (t > sp + close_band)
                        decision = '{act: 1'b1, open: 1'b0};
                end
                if (decision.act && decision.open)
                    opened = 1'b1;
                if (decision.act && vent_open[i] != decision.open) begin
                    vent_open[i] = decision.open;
                    changed[i]   = 1'b1;
                end
            end
            // A running system keeps its relays while anything still opens,
            // even when the mode has changed underneath it.
            if (opened) begin
                if (!running) begin
                    relays      = '0;
                    relays.cool = (mode == MODE_COOL);
                    relays.heat = (mode == MODE_HEAT);
                    fan_count   = FAN_W'(1);
                    running     = 1'b1;
                end
            end
            else if (running) begin
                relays    = '0;
                fan_count = '0;
                running   = 1'b0;
            end
            if (fan_count != 0) begin
                if (fan_count == fan_wait) begin
                    relays.fan = 1'b1;
                    fan_count  = '0;
                end
                else
                    fan_count = fan_count + 1'b1;
            end
            for (int i = 0; i < ROOM_COUNT; i++)
                if (live_count[i] != 0)
                    live_count[i] = live_count[i] - 1'b1;
        end
        else begin
            room_temp[room]  = reading;
            live_count[room] = LIVE_RELOAD;
        end
        w.heat_on       = relays.heat;
        w.cool_on       = relays.cool;
        w.fan_on        = relays.fan;
        w.hvac_running  = running;
        w.vents_open    = vent_open;
        w.vents_changed = changed;
        for (int i = 0; i < ROOM_COUNT; i++)
            w.zones_stale[i] = (live_count[i] == 0);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        status_word_t got;
        status_word_t want;
        if (!rst_n) begin
            setpoint  = SETPOINT_RST;
            mode      = MODE_OFF;
            prio_zone = '0;
            norm_band = NORM_BAND_RST;
            prio_band = PRIO_BAND_RST;
            fan_wait  = FAN_WAIT_RST;
            for (int i = 0; i < ROOM_COUNT; i++) begin
                room_temp[i]  = TEMP_RST;
                live_count[i] = '0;
            end
            vent_open     = '0;
            running       = 1'b0;
            fan_count     = '0;
            relays        = '0;
            expected_status.delete();
            mismatches    = 0;
            pending       = 0;
            words_checked = 0;
        end
        else begin
            // Retire first: a word leaving now always belongs to an older command.
            if (status.valid && status.ready) begin
                got.heat_on       = status.heat_on;
                got.cool_on       = status.cool_on;
                got.fan_on        = status.fan_on;
                got.hvac_running  = status.hvac_running;
                got.vents_open    = status.vents_open;
                got.vents_changed = status.vents_changed;
                got.zones_stale   = status.zones_stale;
                if (expected_status.size() == 0)
                    report_mismatch("word with nothing outstanding", int'(got), 0);
                else begin
                    want = expected_status.pop_front();
                    if (got.heat_on !== want.heat_on)
                        report_mismatch("heat_on", got.heat_on, want.heat_on);
                    if (got.cool_on !== want.cool_on)
                        report_mismatch("cool_on", got.cool_on, want.cool_on);
                    if (got.fan_on !== want.fan_on)
                        report_mismatch("fan_on", got.fan_on, want.fan_on);
                    if (got.hvac_running !== want.hvac_running)
                        report_mismatch("hvac_running", got.hvac_running, want.hvac_running);
                    if (got.vents_open !== want.vents_open)
                        report_mismatch("vents_open", got.vents_open, want.vents_open);
                    if (got.vents_changed !== want.vents_changed)
                        report_mismatch("vents_changed", got.vents_changed, want.vents_changed);
                    if (got.zones_stale !== want.zones_stale)
                        report_mismatch("zones_stale", got.zones_stale, want.zones_stale);
                end
                words_checked++;
            end
            if (cmd.valid && cmd.ready)
                expected_status.push_back(advance_controller(cmd.kind, cmd.room, cmd.reading));
            if (cfg_we) begin
                case (cfg_index)
                    REG_SETPOINT:  setpoint  = cfg_data[TEMP_W-1:0];
                    REG_MODE:      mode      = cfg_data[MODE_W-1:0];
                    REG_PRIO_ZONE: prio_zone = cfg_data[ROOM_W-1:0];
                    REG_NORM_BAND: norm_band = cfg_data[BAND_W-1:0];
                    REG_PRIO_BAND: prio_band = cfg_data[BAND_W-1:0];
                    REG_FAN_WAIT:  fan_wait  = cfg_data[FAN_W-1:0];
                    default: ;
                endcase
            end
            pending = expected_status.size();
        end
    end

endmodule

>>> dv/tb_zone_thermostat_controller.sv
// ============================================================================
// tb_zone_thermostat_controller
// Drives the zone thermostat controller with a directed opening sequence and
// then random phases of room reports and control ticks under changing
// register settings, with random gaps and stalls on both channels. The
// status checker beside the block predicts and compares every status word.
// ============================================================================
module tb_zone_thermostat_controller;
    import ztc_pkg::*;

    localparam int RANDOM_WORDS   = 1230;
    localparam int IDLE_PCT       = 27;
    localparam int HOLD_AFTER     = 250;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int QUIET_PHASE    = 4;

    // Mode code with no name in the package; the block treats it as off.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    pending;
    bit                    no_gaps;
    bit                    hold_done;
    int                    words_drained;

    ztc_cmd_if    cmd_ch ();
    ztc_status_if status_ch ();

    zone_thermostat_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .status    (status_ch)
    );

    ztc_status_checker status_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd_ch),
        .status     (status_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one command word and returns at the edge where it is taken.
    // The valid stays high so that a following word can go back to back.
    task automatic send_word(logic kind, logic [ROOM_W-1:0] room,
                             logic signed [TEMP_W-1:0] reading);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.kind    <= kind;
        cmd_ch.room    <= room;
        cmd_ch.reading <= reading;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    // Stops offering and waits until every predicted word has come back.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Status side: random back-pressure, plus one long hold-off while the
    // sender is still offering, so that the block backs up into its input.
    initial
    begin : status_drain
        status_ch.ready <= 1'b0;
        words_drained = 0;
        hold_done     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (status_ch.valid && status_ch.ready)
                words_drained++;
            if (!hold_done && words_drained >= HOLD_AFTER && cmd_ch.valid)
            begin
                hold_done = 1'b1;
                status_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                status_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("zone_thermostat_controller test failed");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int phase;
        int n_items;
        int tick_pct;
        int roll;
        int value;
        int span;
        int reading;
        int cur_setpoint;
        int cur_norm;
        int cur_prio;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.kind    <= KIND_REPORT;
        cmd_ch.room    <= '0;
        cmd_ch.reading <= '0;
        no_gaps = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: mode off, every room stale until it reports.
        send_word(KIND_TICK, 2'd0, 12'sh000);
        send_word(KIND_REPORT, 2'd0, 12'sh7FF);
        send_word(KIND_REPORT, 2'd1, 12'sh800);
        send_word(KIND_REPORT, 2'd2, 12'sh000);
        send_word(KIND_REPORT, 2'd3, 12'shFFF);
        send_word(KIND_TICK, 2'd3, 12'shFFF);
        settle();

        // Cooling start, then the fan after the default delay.
        write_reg(REG_MODE, MODE_COOL);
        repeat (3) send_word(KIND_TICK, 2'd1, 12'sh555);
        settle();

        // Heating while running keeps the cooling relay; the unused mode stops.
        write_reg(REG_MODE, MODE_HEAT);
        send_word(KIND_TICK, 2'd2, 12'shAAA);
        settle();
        write_reg(REG_MODE, MODE_UNUSED);
        send_word(KIND_TICK, 2'd0, 12'sh000);
        settle();

        // Zero bands around zero; a fan delay of zero never turns the fan on.
        write_reg(REG_SETPOINT, 0);
        write_reg(REG_NORM_BAND, 0);
        write_reg(REG_PRIO_BAND, 0);
        write_reg(REG_PRIO_ZONE, 3);
        write_reg(REG_FAN_WAIT, 0);
        write_reg(REG_MODE, MODE_COOL);
        send_word(KIND_REPORT, 2'd0, 12'sh001);
        send_word(KIND_REPORT, 2'd1, 12'shFFF);
        send_word(KIND_REPORT, 2'd3, 12'sh000);
        send_word(KIND_TICK, 2'd0, 12'sh000);
        send_word(KIND_TICK, 2'd0, 12'sh000);
        settle();

        // Setpoint and bands at their extremes.
        write_reg(REG_SETPOINT, -2048);
        write_reg(REG_NORM_BAND, 255);
        write_reg(REG_PRIO_BAND, 255);
        write_reg(REG_FAN_WAIT, 1);
        write_reg(REG_MODE, MODE_HEAT);
        send_word(KIND_REPORT, 2'd0, 12'sh800);
        send_word(KIND_TICK, 2'd0, 12'sh000);
        settle();
        write_reg(REG_SETPOINT, 2047);
        write_reg(REG_MODE, MODE_COOL);
        send_word(KIND_REPORT, 2'd1, 12'sh7FF);
        send_word(KIND_TICK, 2'd0, 12'sh000);

        cur_setpoint = 2047;
        cur_norm     = 255;
        cur_prio     = 255;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            settle();
            if ($urandom_range(99) < 50)
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                    write_reg(REG_MODE, MODE_COOL);
                else if (roll < 90)
                    write_reg(REG_MODE, MODE_HEAT);
                else if (roll < 96)
                    write_reg(REG_MODE, MODE_OFF);
                else
                    write_reg(REG_MODE, MODE_UNUSED);
            end
            repeat ($urandom_range(1, 3))
            begin
                roll = $urandom_range(99);
                case ($urandom_range(0, 4))
                    0:
                    begin
                        if (roll < 10)
                            value = (roll < 5) ? 2047 : -2048;
                        else if (roll < 30)
                            value = int'($urandom_range(0, 4095)) - 2048;
                        else
                            value = int'($urandom_range(0, 500)) - 200;
                        cur_setpoint = value;
                        write_reg(REG_SETPOINT, value);
                    end
                    1: write_reg(REG_PRIO_ZONE, $urandom_range(0, 3));
                    2:
                    begin
                        value = (roll < 12) ? 0 : (roll < 24) ? 255 : $urandom_range(0, 12);
                        cur_norm = value;
                        write_reg(REG_NORM_BAND, value);
                    end
                    3:
                    begin
                        value = (roll < 12) ? 0 : (roll < 24) ? 255 : $urandom_range(0, 12);
                        cur_prio = value;
                        write_reg(REG_PRIO_BAND, value);
                    end
                    default:
                    begin
                        value = (roll < 5) ? 0 : (roll < 12) ? 255 : $urandom_range(1, 6);
                        write_reg(REG_FAN_WAIT, value);
                    end
                endcase
            end

            // One phase runs with both channels flat out.
            no_gaps  = (phase == QUIET_PHASE);
            n_items  = no_gaps ? 80 : $urandom_range(15, 50);
            tick_pct = $urandom_range(15, 60);
            span     = ((cur_norm > cur_prio) ? cur_norm : cur_prio) + 6;
            for (int k = 0; k < n_items && sent < RANDOM_WORDS; k++)
            begin
                if (!no_gaps)
                    while ($urandom_range(99) < IDLE_PCT)
                    begin
                        cmd_ch.valid <= 1'b0;
                        @(posedge clk);
                    end
                if ($urandom_range(99) < 75)
                begin
                    reading = cur_setpoint + int'($urandom_range(0, 2 * span)) - span;
                    if (reading > 2047)
                        reading = 2047;
                    else if (reading < -2048)
                        reading = -2048;
                end
                else
                    reading = int'($urandom_range(0, 4095)) - 2048;
                if ($urandom_range(99) < tick_pct)
                    send_word(KIND_TICK, ROOM_W'($urandom_range(0, 3)),
                              reading[TEMP_W-1:0]);
                else
                    send_word(KIND_REPORT, ROOM_W'($urandom_range(0, 3)),
                              reading[TEMP_W-1:0]);
                sent++;
            end
            no_gaps = 1'b0;
            phase++;
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("zone_thermostat_controller test passed");
        else
            $display("zone_thermostat_controller test failed");
        $finish;
    end

endmodule
